@@ sv/stp_pkg.sv @@
package stp_pkg;

    // Pool size and wrap point of the shared tick count.
    localparam int NUM_TIMERS = 8;
    localparam int MAX_TICKS  = 30000;

    localparam int OP_W      = 3;
    localparam int HANDLE_W  = 3;
    localparam int STAMP_W   = 16;
    localparam int TMR_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // A 3-bit handle can only name the first eight timers, so allocation
    // searches no further than that.
    localparam int HANDLE_SPAN = 1 << HANDLE_W;
    localparam int SCAN_SPAN   = (NUM_TIMERS < HANDLE_SPAN) ? NUM_TIMERS : HANDLE_SPAN;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_RESTART = 3'd2,
        OP_READ    = 3'd3,
        OP_RELEASE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_CALC,
        ST_WRAP_RD,
        ST_WRAP_WR,
        ST_ALLOC
    } t_state;

endpackage

@@ sv/software_timer_pool.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_operation, i_handle
// result    out        o_out_valid / i_out_stall  o_granted, o_given_handle, o_elapsed
//
// Tick without wrap, restart, release and unknown operations finish in the
// accepting cycle. A read passes through ST_READ_CALC, since the read port
// of the stamp memory is registered. Allocate tests one busy flag per cycle
// in ST_ALLOC, up to SCAN_SPAN flags. A tick that wraps the count visits
// every timer: each stamp is read in ST_WRAP_RD, then, if the timer is busy,
// corrected by the shared subtractor in ST_WRAP_WR.
// Reset (synchronous, active low) clears the count, the busy flags, the
// sequencer and the valid flag of the result register, not its data or the stamps.
// A new beat is taken only while the sequencer is idle and the result
// register is empty or being drained in the same cycle.
module software_timer_pool
    import stp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_granted,
    output logic [HANDLE_W-1:0] o_given_handle,
    output logic [STAMP_W-1:0]  o_elapsed
);

    // Sequencer state, scan index, tick count and busy flags.
    t_state                r_state, n_state;
    logic [TMR_IDX_W-1:0]  r_idx, n_idx;
    logic [STAMP_W-1:0]    r_tick_count, n_tick_count;
    logic [NUM_TIMERS-1:0] r_busy, n_busy;

    // Result register. It decouples the sequencer from the output stall.
    logic                  r_out_valid;
    logic                  r_granted;
    logic [HANDLE_W-1:0]   r_given;
    logic [STAMP_W-1:0]    r_elapsed;
    logic                  n_out_load;
    logic                  n_granted;
    logic [HANDLE_W-1:0]   n_given;
    logic [STAMP_W-1:0]    n_elapsed;

    // Start stamp memory: one write port, one read port with registered data.
    logic [STAMP_W-1:0]    r_stamps [NUM_TIMERS];
    logic [STAMP_W-1:0]    r_rd_data;
    logic                  mem_we;
    logic [TMR_IDX_W-1:0]  mem_waddr;
    logic [STAMP_W-1:0]    mem_wdata;
    logic                  mem_re;
    logic [TMR_IDX_W-1:0]  mem_raddr;

    // The one subtractor that ticks, reads and the wrap share.
    logic [STAMP_W-1:0]    unit_a;
    logic [STAMP_W-1:0]    unit_b;
    logic [STAMP_W-1:0]    unit_diff;

    logic                  in_accept;
    logic                  in_pool;
    logic [TMR_IDX_W-1:0]  h_idx;
    logic                  idx_last;
    logic                  scan_last;

    assign unit_diff = unit_a - unit_b;

    assign in_accept = i_in_valid && !o_in_stall;
    assign in_pool   = int'(i_handle) < NUM_TIMERS;
    assign h_idx     = TMR_IDX_W'(i_handle);
    assign idx_last  = (r_idx == TMR_IDX_W'(NUM_TIMERS - 1));
    assign scan_last = (r_idx == TMR_IDX_W'(SCAN_SPAN - 1));

    assign o_in_stall     = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_granted;
    assign o_given_handle = r_given;
    assign o_elapsed      = r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_tick_count <= '0;
            r_busy       <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_tick_count <= n_tick_count;
            r_busy       <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_granted <= n_granted;
            r_given   <= n_given;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stamps[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_stamps[mem_raddr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_tick_count = r_tick_count;
        n_busy       = r_busy;
        n_out_load   = 1'b0;
        n_granted    = 1'b0;
        n_given      = '0;
        n_elapsed    = '0;
        mem_we       = 1'b0;
        mem_waddr    = h_idx;
        mem_wdata    = r_tick_count;
        mem_re       = 1'b0;
        mem_raddr    = h_idx;
        unit_a       = r_tick_count;
        unit_b       = r_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (t_op'(i_operation))
                        OP_TICK: begin
                            // Adding one is subtracting all ones.
                            unit_b       = '1;
                            n_tick_count = unit_diff;
                            if (unit_diff >= STAMP_W'(MAX_TICKS)) begin
                                // The count has wrapped: shift every busy
                                // stamp back by it before clearing it.
                                n_idx   = '0;
                                n_state = ST_WRAP_RD;
                            end else begin
                                n_out_load = 1'b1;
                            end
                        end
                        OP_ALLOC: begin
                            n_idx   = '0;
                            n_state = ST_ALLOC;
                        end
                        OP_RESTART: begin
                            mem_we     = in_pool;
                            n_out_load = 1'b1;
                        end
                        OP_READ: begin
                            if (in_pool) begin
                                mem_re  = 1'b1;
                                n_state = ST_READ_CALC;
                            end else begin
                                n_out_load = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            if (in_pool) begin
                                n_busy[h_idx] = 1'b0;
                            end
                            n_out_load = 1'b1;
                        end
                        default: begin
                            n_out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_CALC: begin
                n_elapsed  = unit_diff;
                n_out_load = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_WRAP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = ST_WRAP_WR;
            end
            ST_WRAP_WR: begin
                unit_a    = r_rd_data;
                unit_b    = r_tick_count;
                mem_we    = r_busy[r_idx];
                mem_waddr = r_idx;
                mem_wdata = unit_diff;
                if (idx_last) begin
                    n_tick_count = '0;
                    n_out_load   = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_WRAP_RD;
                end
            end
            ST_ALLOC: begin
                if (!r_busy[r_idx]) begin
                    n_busy[r_idx] = 1'b1;
                    n_granted     = 1'b1;
                    n_given       = HANDLE_W'(r_idx);
                    n_out_load    = 1'b1;
                    n_state       = ST_IDLE;
                end else if (scan_last) begin
                    // Every timer that a handle can name is taken.
                    n_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The sequencer never takes a beat while it is working on one.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input taken while the sequencer is busy");

    // Between items the count always sits below the wrap point.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_tick_count < STAMP_W'(MAX_TICKS)))
        else $error("tick count left at or above the wrap point");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten before it was taken");

    // A granted timer is marked busy from the next cycle on.
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_load && n_granted) |=> r_busy[$past(r_idx)])
        else $error("granted timer not marked busy");

endmodule

@@ dv/pool_check_pkg.sv @@
`timescale 1ns / 100ps

package pool_check_pkg;
    import stp_pkg::*;

    typedef struct packed {
        logic                granted;
        logic [HANDLE_W-1:0] given_handle;
        logic [STAMP_W-1:0]  elapsed;
    } t_pool_answer;

    // Tracks the timer pool beat by beat and holds the answers still owed.
    class t_pool_scoreboard;
        logic [STAMP_W-1:0] count;
        bit                 busy [NUM_TIMERS];
        logic [STAMP_W-1:0] stamps [NUM_TIMERS];
        bit                 stamp_known [NUM_TIMERS];
        t_pool_answer       answers_due [$];
        int                 mismatches;

        function new();
            count      = '0;
            mismatches = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                busy[i]        = 1'b0;
                stamps[i]      = '0;
                stamp_known[i] = 1'b0;
            end
        endfunction

        // Apply one accepted command to the pool state and queue its answer.
        function void note_command(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h);
            t_pool_answer ans;
            bit           in_pool;
            bit           found;
            ans     = '0;
            in_pool = int'(h) < NUM_TIMERS;
            found   = 1'b0;
            case (op)
                OP_TICK: begin
                    count = count + 1'b1;
                    // On the wrap, busy timers are rebased so elapsed times survive.
                    if (int'(count) >= MAX_TICKS) begin
                        for (int i = 0; i < NUM_TIMERS; i++) begin
                            if (busy[i]) stamps[i] = stamps[i] - count;
                        end
                        count = '0;
                    end
                end
                OP_ALLOC: begin
                    for (int i = 0; i < SCAN_SPAN; i++) begin
                        if (!found && !busy[i]) begin
                            busy[i]          = 1'b1;
                            found            = 1'b1;
                            ans.granted      = 1'b1;
                            ans.given_handle = HANDLE_W'(i);
                        end
                    end
                end
                OP_RESTART: begin
                    if (in_pool) begin
                        stamps[h]      = count;
                        stamp_known[h] = 1'b1;
                    end
                end
                OP_READ: begin
                    if (in_pool) ans.elapsed = count - stamps[h];
                end
                OP_RELEASE: begin
                    if (in_pool) busy[h] = 1'b0;
                end
                default: ;
            endcase
            answers_due.push_back(ans);
        endfunction

        function void check_answer(logic g, logic [HANDLE_W-1:0] gh, logic [STAMP_W-1:0] el);
            t_pool_answer want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none due: granted=%0d handle=%0d elapsed=%0d",
                             $time, g, gh, el);
                return;
            end
            want = answers_due.pop_front();
            if (g !== want.granted || gh !== want.given_handle || el !== want.elapsed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected g=%0d h=%0d e=%0d, got g=%0d h=%0d e=%0d",
                             $time, want.granted, want.given_handle, want.elapsed,
                             g, gh, el);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench
    import stp_pkg::*;
    import pool_check_pkg::*;
();

    // This limit only catches hangs.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HANDLE_MAX   = (1 << HANDLE_W) - 1;
    localparam int OP_LAST      = (1 << OP_W) - 1;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 50;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_operation;
    logic [HANDLE_W-1:0] i_handle;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_granted;
    logic [HANDLE_W-1:0] o_given_handle;
    logic [STAMP_W-1:0]  o_elapsed;

    t_pool_scoreboard board;
    bit             quiet_tail  = 1'b0;
    bit             rx_hold_req = 1'b0;
    int             rx_burst    = 0;
    int             cycles      = 0;

    software_timer_pool u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_handle       (i_handle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted      (o_granted),
        .o_given_handle (o_given_handle),
        .o_elapsed      (o_elapsed)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog. A run that stops making progress ends here as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Every result beat taken by the receiver is checked against the oldest
    // answer still owed. Sampling at the rising edge sees the values that the
    // edge itself acts on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_answer(o_granted, o_given_handle, o_elapsed);
    end

    // Receiver side. It stalls in short random bursts, or for one long
    // stretch on request so that the result register backs up into the input.
    // The long stretch is counted here, independent of the sender.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_burst    = LONG_HOLD;
            end else if (rx_burst == 0 && !quiet_tail && $urandom_range(0, 99) < 15) begin
                rx_burst = $urandom_range(1, 8);
            end
            if (rx_burst > 0) begin
                i_out_stall = 1'b1;
                rx_burst--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // Offer one command beat and hold it until the block takes it. Valid stays
    // high across back-to-back beats, since the next call only updates the payload.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_operation = op;
        i_handle    = h;
        do @(posedge i_clk); while (o_in_stall);
        board.note_command(op, h);
    endtask

    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Hold the input quiet until every owed answer has come back.
    task automatic wait_drained();
        idle_input(1);
        while (board.pending() > 0) @(posedge i_clk);
    endtask

    // Walk from a random start to the nearest timer that is busy (or, with
    // want_busy clear, whose stamp has been written). Falls back to the start.
    function automatic logic [HANDLE_W-1:0] nearby_handle(logic [HANDLE_W-1:0] start,
                                                          bit want_busy);
        logic [HANDLE_W-1:0] h;
        h = start;
        for (int k = 0; k <= HANDLE_MAX; k++) begin
            if (want_busy ? board.busy[h] : board.stamp_known[h]) return h;
            h = h + 1'b1;
        end
        return start;
    endfunction

    // One random command. Most are meaningful for the current pool state:
    // restarts and releases lean toward busy timers, and reads only go to
    // timers whose stamp exists, since an unwritten stamp is never read.
    task automatic random_command();
        int                  pick;
        logic [HANDLE_W-1:0] h;
        pick = $urandom_range(0, 99);
        h    = HANDLE_W'($urandom_range(0, HANDLE_MAX));
        if (!quiet_tail && $urandom_range(0, 99) < 15) idle_input($urandom_range(1, 8));
        if (pick < 35) begin
            send_command(OP_TICK, h);
        end else if (pick < 47) begin
            send_command(OP_ALLOC, h);
        end else if (pick < 62) begin
            if ($urandom_range(0, 3) != 0) h = nearby_handle(h, 1'b1);
            send_command(OP_RESTART, h);
        end else if (pick < 87) begin
            h = nearby_handle(h, 1'b0);
            if (board.stamp_known[h]) send_command(OP_READ, h);
            else send_command(OP_RESTART, h);
        end else if (pick < 97) begin
            if ($urandom_range(0, 3) != 0) h = nearby_handle(h, 1'b1);
            send_command(OP_RELEASE, h);
        end else begin
            send_command(OP_W'($urandom_range(OP_RELEASE + 1, OP_LAST)), h);
        end
    endtask

    initial begin
        board       = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_TICK;
        i_handle    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Fill the pool, then one allocate more than it holds.
        for (int i = 0; i <= SCAN_SPAN; i++) send_command(OP_ALLOC, '0);
        send_command(OP_RESTART, 3'd0);
        send_command(OP_RESTART, 3'(HANDLE_MAX));
        send_command(OP_TICK, 3'(HANDLE_MAX));
        send_command(OP_TICK, 3'd0);
        send_command(OP_READ, 3'd0);
        send_command(OP_READ, 3'(HANDLE_MAX));
        // Unknown operations do nothing and answer all zeros.
        for (int op = OP_RELEASE + 1; op <= OP_LAST; op++)
            send_command(OP_W'(op), 3'(HANDLE_MAX - op));
        // A released timer is handed out again as the lowest free one.
        send_command(OP_RELEASE, 3'd3);
        send_command(OP_ALLOC, 3'd5);
        // A freed timer still answers reads and takes restarts.
        send_command(OP_RELEASE, 3'(HANDLE_MAX));
        send_command(OP_TICK, 3'd2);
        send_command(OP_READ, 3'(HANDLE_MAX));
        send_command(OP_RESTART, 3'(HANDLE_MAX));
        send_command(OP_READ, 3'(HANDLE_MAX));
        wait_drained();

        // First random section. Partway in, the receiver holds off for a
        // long stretch while beats keep being offered.
        for (int i = 0; i < 450; i++) begin
            if (i == 200) rx_hold_req = 1'b1;
            random_command();
        end
        wait_drained();

        // Second random section; its last part runs with no idling on either
        // side.
        for (int i = 0; i < 475; i++) begin
            if (i == 325) quiet_tail = 1'b1;
            random_command();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/stp_pkg.sv
sv/software_timer_pool.sv
dv/pool_check_pkg.sv
dv/testbench.sv
